>>> sv/iss_pkg.sv
// Shared types and codes for the indexed stack store.
package iss_pkg;

    // Command codes carried on the input tuser
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SCAN,
        S_DONE
    } state_t;

    // Memory address source
    typedef enum logic [2:0] {
        ADR_COUNT,
        ADR_TOP,
        ADR_SLOT,
        ADR_SLOTM1,
        ADR_SCAN
    } adr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       mem_we;
        logic       mem_re;
        adr_sel_t   adr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_status;
        logic [2:0] status_code;
        logic       cap_rd;
        logic       scan_step;
        logic       set_found;
        logic       out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       zero;
        logic       read_ok;
        logic       write_ok;
        logic       match;
        logic       scan_end;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> sv/iss_ctrl.sv
// Command sequencer for the indexed stack store.
module iss_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  iss_pkg::dp_stat_t stat,
    output iss_pkg::dp_cmd_t  cmd,
    output logic             in_ready
);
    import iss_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.adr_sel = ADR_COUNT;
        cmd.status_code = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load_in = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (stat.cmd)
                    CMD_PUSH: begin
                        if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ST_FULL;
                        end else begin
                            cmd.mem_we = 1'b1;
                            cmd.adr_sel = ADR_COUNT;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (stat.zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end else begin
                            cmd.mem_re = 1'b1;
                            cmd.adr_sel = ADR_TOP;
                            cmd.cnt_dec = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_READ: begin
                        if (!stat.read_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ST_RANGE;
                        end else begin
                            cmd.mem_re = 1'b1;
                            cmd.adr_sel = ADR_SLOT;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_WRITE: begin
                        if (!stat.write_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ST_RANGE;
                        end else begin
                            cmd.mem_we = 1'b1;
                            cmd.adr_sel = ADR_SLOTM1;
                        end
                    end
                    CMD_SEARCH: begin
                        if (stat.zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ST_NOTFOUND;
                        end else begin
                            cmd.mem_re = 1'b1;
                            cmd.adr_sel = ADR_SCAN;
                            cmd.scan_step = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        // unknown command: no change, status ok
                    end
                endcase
            end
            S_WAIT: begin
                cmd.cap_rd = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN: begin
                // compare the entry fetched last cycle; with no match and not at the end, fetch the next one
                if (stat.match) begin
                    cmd.set_found = 1'b1;
                    state_next = S_DONE;
                end else if (stat.scan_end) begin
                    cmd.set_status = 1'b1;
                    cmd.status_code = ST_NOTFOUND;
                    state_next = S_DONE;
                end else begin
                    cmd.mem_re = 1'b1;
                    cmd.adr_sel = ADR_SCAN;
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/iss_dp.sv
// Datapath for the indexed stack store: entry memory, count, result and output registers.
module iss_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  iss_pkg::dp_cmd_t    cmd,
    output iss_pkg::dp_stat_t   stat,
    input  logic [2:0]          in_cmd,
    input  logic [6:0]          in_slot,
    input  logic signed [31:0]  in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_result_value,
    output logic [6:0]          out_found_position,
    output logic [2:0]          out_status,
    output logic [6:0]          out_held_count,
    output logic                out_is_empty
);
    import iss_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    logic [31:0] mem [CAPACITY];

    logic [2:0]         cmd_reg;
    logic [6:0]         slot_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      scan_idx_reg;
    logic [31:0]        rd_data_reg;
    logic signed [31:0] res_value_reg;
    logic [6:0]         found_reg;
    logic [2:0]         status_reg;
    logic               m_valid_reg;

    logic [XW-1:0] slot_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] scan_x;
    logic [IW-1:0] addr;

    assign slot_x  = XW'(slot_reg);
    assign count_x = XW'(count_reg);
    assign scan_x  = XW'(scan_idx_reg);

    // Status toward the controller
    assign stat.cmd      = cmd_reg;
    assign stat.full     = (count_reg >= CW'(CAPACITY));
    assign stat.zero     = (count_reg == '0);
    assign stat.read_ok  = (slot_x < count_x);
    assign stat.write_ok = (slot_x != '0) && (slot_x <= count_x);
    assign stat.match    = (rd_data_reg == value_reg);
    assign stat.scan_end = (scan_idx_reg == count_reg);
    assign stat.out_free = !m_valid_reg || out_ready;

    // Memory address select
    always_comb begin
        unique case (cmd.adr_sel)
            ADR_COUNT:  addr = count_reg[IW-1:0];
            ADR_TOP:    addr = IW'(count_x - XW'(1));
            ADR_SLOT:   addr = IW'(slot_x);
            ADR_SLOTM1: addr = IW'(slot_x - XW'(1));
            ADR_SCAN:   addr = scan_idx_reg[IW-1:0];
            default:    addr = '0;
        endcase
    end

    // Entry memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[addr] <= value_reg;
        end
        if (cmd.mem_re) begin
            rd_data_reg <= mem[addr];
        end
    end

    // Captured transaction and result fields
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg       <= in_cmd;
            slot_reg      <= in_slot;
            value_reg     <= in_value;
            res_value_reg <= '0;
            found_reg     <= '0;
            status_reg    <= ST_OK;
            scan_idx_reg  <= '0;
        end else begin
            if (cmd.set_status) begin
                status_reg <= cmd.status_code;
            end
            if (cmd.cap_rd) begin
                res_value_reg <= rd_data_reg;
            end
            if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (cmd.set_found) begin
                found_reg <= 7'(scan_x);
            end
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_result_value   <= res_value_reg;
            out_found_position <= found_reg;
            out_status         <= status_reg;
            out_held_count     <= 7'(count_x);
            out_is_empty       <= (count_reg == '0);
        end
    end

    assign out_valid = m_valid_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending transaction");

    a_inc_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> !stat.full)
        else $error("push accepted while full");

    a_dec_not_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> !stat.zero)
        else $error("pop accepted while empty");

endmodule

>>> sv/indexed_stack_store_top.sv
// Top level of the indexed stack store: stream ports, sequencer and datapath.
//
// Input channel s_*: one transaction is one command. s_tuser carries the
// command code (push, pop, read, write, search), s_tdata the slot and value.
// Output channel m_*: exactly one result transaction per command, in order.
// From acceptance, every command passes through the execute state, the done
// state and the output register; pop and read add a wait state for the
// registered memory read. Search compares held entries until a match or the
// end of the held entries, at most CAPACITY of them, walking the entry memory
// one entry per cycle through its single registered read port.
// s_tready is high only while no command is in progress; the next command
// is taken while a finished result still waits in the output register.
// A stalled receiver holds the result in the output register and, once the
// following command is done, holds that command until the register is free.
// Reset (aresetn low, synchronous) empties the store and drops any pending
// result; the entry memory itself is not cleared.
module indexed_stack_store_top #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] slot, [38:7] data_value, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [31:0] result_value, [38:32] found_position,
                                   // [41:39] status, [48:42] held_count,
                                   // [49] is_empty, [55:50] zero
);
    import iss_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     in_ready;
    logic     in_fire;

    logic signed [31:0] result_value;
    logic [6:0]         found_position;
    logic [2:0]         status;
    logic [6:0]         held_count;
    logic               is_empty;

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;

    iss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .stat     (dp_stat),
        .cmd      (dp_cmd),
        .in_ready (in_ready)
    );

    iss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (dp_cmd),
        .stat               (dp_stat),
        .in_cmd             (s_tuser),
        .in_slot            (s_tdata[6:0]),
        .in_value           (s_tdata[38:7]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_result_value   (result_value),
        .out_found_position (found_position),
        .out_status         (status),
        .out_held_count     (held_count),
        .out_is_empty       (is_empty)
    );

    // Pack the result transaction
    assign m_tdata = {6'd0, is_empty, held_count, status, found_position, result_value};

endmodule
